### rtl/core/lrumtf_pkg.sv
// ----------------------------------------------------------------------------
// lrumtf_pkg
// shared constants, payload structs and controller/datapath links for the
// move-to-front lru cache
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrumtf_pkg;

   localparam int CAPACITY      = 128;
   localparam int KEY_WIDTH     = 16;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int COUNT_WIDTH   = $clog2(CAPACITY + 1);

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_STORE  = 1'b1;

   typedef logic [KEY_WIDTH-1:0]     key_type;
   typedef logic [PAYLOAD_WIDTH-1:0] payload_type;
   typedef logic [COUNT_WIDTH-1:0]   count_type;
   typedef logic [CAPACITY-1:0]      cell_vec_type;

   typedef struct packed {
      logic        operation;
      logic [15:0] lookup_key;
      logic [31:0] store_payload;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] found_payload;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic select;
      logic update;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic store_op;
   } status_type;

endpackage

`default_nettype wire

### rtl/core/lru_move_to_front_cache.sv
// ----------------------------------------------------------------------------
// lru_move_to_front_cache
// fully associative lru cache, entries held in recency order, front first
// ----------------------------------------------------------------------------
// a lookup result is written to the output register in the update step
// steps per item: compare on accept, select, update; no new item is taken until update ends
// the output register holds one result; a lookup waits in update while it is stalled
// reset clears occupancy and control; cell contents are left as they are
`timescale 1ns / 1ps
`default_nettype none

module lru_move_to_front_cache (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire lrumtf_pkg::req_type req_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output lrumtf_pkg::rsp_type      rsp_item
);
   import lrumtf_pkg::*;

   cmd_type    cmd;
   status_type status;

   lrumtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   lrumtf_cells u_cells (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

### rtl/core/lrumtf_ctrl.sv
// ----------------------------------------------------------------------------
// lrumtf_ctrl
// sequencer: capture and compare, select the match, update the cells and
// hand the lookup item to the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrumtf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lrumtf_pkg::cmd_type        cmd,
   input  wire lrumtf_pkg::status_type status
);
   import lrumtf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SELECT = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_blocked;

   assign rsp_blocked = rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SELECT;
            end
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.store_op || !rsp_blocked) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.update && !status.store_op) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // an accepted item always goes on to the select step
   a_accept_to_select: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SELECT))
      else $error("accepted item did not reach select");

   // a new result only appears from the update step of a lookup
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_UPDATE && !$past(status.store_op)))
      else $error("result raised outside a lookup update");

   // the update never overwrites a result still held by a stall
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !status.store_op) |-> !rsp_blocked)
      else $error("result overwritten while stalled");

   // only one command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one command asserted");

endmodule

`default_nettype wire

### rtl/core/lrumtf_cells.sv
// ----------------------------------------------------------------------------
// lrumtf_cells
// row of key/payload cells in recency order with per-cell compare, match
// selection, move-to-front shift and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrumtf_cells (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lrumtf_pkg::req_type    req_item,
   input  wire lrumtf_pkg::cmd_type    cmd,
   output lrumtf_pkg::status_type      status,
   output lrumtf_pkg::rsp_type         rsp_item
);
   import lrumtf_pkg::*;

   key_type      keys_ff     [CAPACITY];
   payload_type  payloads_ff [CAPACITY];
   count_type    count_ff, count_in;
   req_type      req_ff;
   cell_vec_type match_ff, match_in;
   cell_vec_type suffix_ff, suffix_in;
   logic         hit_ff, hit_in;
   payload_type  sel_payload_ff, sel_payload_in;
   rsp_type      rsp_ff;
   key_type      req_key;
   payload_type  req_payload;
   payload_type  front_payload;
   logic         is_store;

   assign req_key     = req_ff.lookup_key[KEY_WIDTH-1:0];
   assign req_payload = req_ff.store_payload[PAYLOAD_WIDTH-1:0];
   assign is_store    = (req_ff.operation == OP_STORE);

   // per-cell compare against the incoming key, occupied cells only
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (keys_ff[i] == req_item.lookup_key[KEY_WIDTH-1:0])
                       && (COUNT_WIDTH'(i) < count_ff);
      end
   end

   // cells ahead of and at the match
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         suffix_in[i] = |(match_ff & ({CAPACITY{1'b1}} << i));
      end
   end

   always_comb begin
      sel_payload_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_payload_in = sel_payload_in | (payloads_ff[i] & {PAYLOAD_WIDTH{match_ff[i]}});
      end
   end

   assign hit_in        = |match_ff;
   assign front_payload = is_store ? req_payload : sel_payload_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.update && is_store && !hit_ff && (count_ff < COUNT_WIDTH'(CAPACITY))) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         match_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.capture) begin
            match_ff <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.select) begin
         suffix_ff      <= suffix_in;
         hit_ff         <= hit_in;
         sel_payload_ff <= sel_payload_in;
      end
   end

   // move to front: cell 0 takes the item, cells up to the match move back (all cells on a store miss)
   always_ff @(posedge clock) begin
      if (cmd.update && (hit_ff || is_store)) begin
         keys_ff[0]     <= req_key;
         payloads_ff[0] <= front_payload;
         for (int i = 1; i < CAPACITY; i++) begin
            if (!hit_ff || suffix_ff[i]) begin
               keys_ff[i]     <= keys_ff[i-1];
               payloads_ff[i] <= payloads_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && !is_store) begin
         rsp_ff.hit           <= hit_ff;
         rsp_ff.found_payload <= hit_ff ? 32'(sel_payload_ff) : '0;
      end
   end

   assign status.store_op = is_store;
   assign rsp_item        = rsp_ff;

   // occupancy never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(CAPACITY))
      else $error("occupancy above capacity");

   // keys are unique among occupied cells
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_ff))
      else $error("more than one cell matched");

endmodule

`default_nettype wire
